FILE: rtl/spd_pkg.sv
// Package for the sensor packet deframer: result record, kind and status
// codes, configuration register indexes and reset values. No dependencies.
`default_nettype none

package spd_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 256;

  localparam logic [15:0] START_CODE_RESET     = 16'hEF01;
  localparam logic [31:0] DEVICE_ADDRESS_RESET = 32'hFFFF_FFFF;
  localparam logic [7:0]  ACK_PACKET_ID_RESET  = 8'h07;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_START_CODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_PACKET_ID  = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_CHECKSUM   = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] packet_id;
    logic [7:0] conf_code;
    logic [8:0] payload_len;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/spd_rx_if.sv
// Byte input channel of the sensor packet deframer: valid/ready transfer
// of one received byte and its end-of-buffer mark. No dependencies.
`default_nettype none

interface spd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/spd_res_if.sv
// Result channel of the sensor packet deframer: valid/ready transfer of a
// payload byte or a packet status. No dependencies.
`default_nettype none

interface spd_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic [7:0] packet_id;
  logic [7:0] conf_code;
  logic [8:0] payload_len;

  modport source (
    output valid, output result_kind, output data_byte, output status,
    output packet_id, output conf_code, output payload_len, input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input status,
    input packet_id, input conf_code, input payload_len, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sensor_packet_deframer.sv
// Sensor packet deframer top level: header check, length check, payload
// pass-through and additive checksum. Uses spd_pkg, spd_rx_if, spd_res_if.
//
// Usage:
//   rx  : one received byte per transfer, with buffer_end marking the last
//         byte currently in the buffer.
//   res : zero or one result per byte: a payload byte (result_kind 0) as
//         soon as it arrives, or one status per packet (result_kind 1).
//   cfg : write start_code, device_address or ack_packet_id by index while
//         the block is idle.
// Timing: one byte per cycle sustained while rx.ready is high. A result is
// registered when its byte is transferred in; the per-byte state update is a
// single registered step, so bytes may follow back to back.
// Stall: results sit in an output register backed by a one-entry skid
// buffer; rx.ready drops only while that skid buffer is full, and it is a
// register, so no combinational path runs from res.ready to rx.ready.
// Reset: rst clears the parser to wait for the first start-code byte,
// empties both result slots and loads the register reset values.
`default_nettype none

module sensor_packet_deframer
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  spd_rx_if.sink                      rx,
  spd_res_if.source                   res,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_PAYLOAD + 2);

  localparam logic [1:0] PH_HEAD   = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_SUM_HI = 2'd2;
  localparam logic [1:0] PH_SUM_LO = 2'd3;

  logic [15:0] start_code;
  logic [31:0] device_address;
  logic [7:0]  ack_packet_id;

  logic [1:0]    phase, phase_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   packet_length, packet_length_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [7:0]    held_id, held_id_next;
  logic [7:0]    held_conf, held_conf_next;
  logic [7:0]    sum_high_byte, sum_high_byte_next;
  logic          header_bad, header_bad_next;

  logic    out_valid, skid_valid;
  result_t out_q, skid_q;

  logic          rx_fire, res_fire;
  logic          produce, done;
  result_t       result;
  logic [7:0]    b;
  logic          is_ack;
  logic [7:0]    expected;
  logic [15:0]   sum_add;
  logic [15:0]   min_len;
  logic [CW-1:0] count_after;
  logic [CW-1:0] plen_count;
  logic [15:0]   plen_wide;

  assign rx.ready = !skid_valid;
  assign rx_fire  = rx.valid && !skid_valid;
  assign res_fire = out_valid && res.ready;

  assign b           = rx.rx_byte;
  assign is_ack      = (held_id == ack_packet_id);
  assign sum_add     = running_sum + 16'(b);
  assign count_after = byte_count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code     <= START_CODE_RESET;
      device_address <= DEVICE_ADDRESS_RESET;
      ack_packet_id  <= ACK_PACKET_ID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_CODE:     start_code     <= cfg_data[15:0];
        REG_DEVICE_ADDRESS: device_address <= cfg_data;
        REG_ACK_PACKET_ID:  ack_packet_id  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (byte_count[2:0])
      3'd0:    expected = start_code[15:8];
      3'd1:    expected = start_code[7:0];
      3'd2:    expected = device_address[31:24];
      3'd3:    expected = device_address[23:16];
      3'd4:    expected = device_address[15:8];
      default: expected = device_address[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    packet_length_next = packet_length;
    running_sum_next   = running_sum;
    held_id_next       = held_id;
    held_conf_next     = held_conf;
    sum_high_byte_next = sum_high_byte;
    header_bad_next    = header_bad;
    produce            = 1'b0;
    done               = 1'b0;
    plen_count         = '0;
    min_len            = is_ack ? 16'd3 : 16'd2;
    result             = '0;
    result.result_kind = KIND_STATUS;
    result.status      = ST_OK;

    unique case (phase)
      PH_HEAD: begin
        if (byte_count < CW'(6)) begin
          if (b != expected) header_bad_next = 1'b1;
        end else if (byte_count == CW'(6)) begin
          held_id_next     = b;
          running_sum_next = sum_add;
        end else if (byte_count == CW'(7)) begin
          packet_length_next = {b, 8'h00};
          running_sum_next   = sum_add;
        end else begin
          packet_length_next = {packet_length[15:8], b};
          running_sum_next   = sum_add;
        end
        if (byte_count < CW'(8)) begin
          byte_count_next = count_after;
          if (rx.buffer_end) begin
            done          = 1'b1;
            result.status = ST_SHORT;
          end
        end else if (header_bad) begin
          done          = 1'b1;
          result.status = ST_BAD_HEADER;
        end else if (packet_length_next < min_len ||
                     (packet_length_next - min_len) > 16'(MAX_PAYLOAD)) begin
          done          = 1'b1;
          result.status = ST_BAD_LENGTH;
        end else if (rx.buffer_end) begin
          done          = 1'b1;
          result.status = ST_INCOMPLETE;
        end else begin
          byte_count_next = '0;
          phase_next      = (packet_length_next > 16'd2) ? PH_BODY : PH_SUM_HI;
        end
      end
      PH_BODY: begin
        running_sum_next = sum_add;
        byte_count_next  = count_after;
        if (16'(count_after) >= packet_length - 16'd2) phase_next = PH_SUM_HI;
        if (is_ack && byte_count == '0) begin
          held_conf_next = b;
          if (rx.buffer_end) begin
            done          = 1'b1;
            result.status = ST_INCOMPLETE;
          end
        end else if (rx.buffer_end) begin
          done          = 1'b1;
          result.status = ST_INCOMPLETE;
          plen_count    = (is_ack && byte_count != '0) ? byte_count - CW'(1) : byte_count;
        end else begin
          produce            = 1'b1;
          result.result_kind = KIND_PAYLOAD;
          result.data_byte   = b;
          plen_count         = is_ack ? byte_count : count_after;
        end
      end
      PH_SUM_HI: begin
        sum_high_byte_next = b;
        if (rx.buffer_end) begin
          done          = 1'b1;
          result.status = ST_INCOMPLETE;
          plen_count    = (is_ack && byte_count != '0) ? byte_count - CW'(1) : byte_count;
        end else begin
          phase_next = PH_SUM_LO;
        end
      end
      PH_SUM_LO: begin
        done          = 1'b1;
        result.status = ({sum_high_byte, b} == running_sum) ? ST_OK : ST_CHECKSUM;
        plen_count    = (is_ack && byte_count != '0) ? byte_count - CW'(1) : byte_count;
      end
      default: ;
    endcase

    plen_wide          = 16'(plen_count);
    result.packet_id   = held_id_next;
    result.conf_code   = held_conf_next;
    result.payload_len = plen_wide[8:0];

    if (done) begin
      produce            = 1'b1;
      phase_next         = PH_HEAD;
      byte_count_next    = '0;
      packet_length_next = '0;
      running_sum_next   = '0;
      held_id_next       = '0;
      held_conf_next     = '0;
      sum_high_byte_next = '0;
      header_bad_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD;
      byte_count    <= '0;
      packet_length <= '0;
      running_sum   <= '0;
      held_id       <= '0;
      held_conf     <= '0;
      sum_high_byte <= '0;
      header_bad    <= 1'b0;
    end else if (rx_fire) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      packet_length <= packet_length_next;
      running_sum   <= running_sum_next;
      held_id       <= held_id_next;
      held_conf     <= held_conf_next;
      sum_high_byte <= sum_high_byte_next;
      header_bad    <= header_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (rx_fire && produce) begin
      if (out_valid && !res.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (res_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_fire) out_q <= skid_q;
    end else if (rx_fire && produce) begin
      if (out_valid && !res.ready) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.result_kind = out_q.result_kind;
  assign res.data_byte   = out_q.data_byte;
  assign res.status      = out_q.status;
  assign res.packet_id   = out_q.packet_id;
  assign res.conf_code   = out_q.conf_code;
  assign res.payload_len = out_q.payload_len;

endmodule

`default_nettype wire

FILE: rtl/spd_checker.sv
// Port-level checks for the sensor packet deframer, attached by bind.
// Depends on spd_pkg and the ports of sensor_packet_deframer.
`default_nettype none

module spd_checker
  import spd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rx_ready,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic       res_kind,
  input wire logic [2:0] res_status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_PAYLOAD |-> res_status == ST_OK)
    else $error("payload result carries a status");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid && rx_ready)
    else $error("result or stall present after reset");

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid)
    else $error("input stalled with no pending result");

endmodule

bind sensor_packet_deframer spd_checker u_spd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_ready   (rx.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_kind   (res.result_kind),
  .res_status (res.status)
);

`default_nettype wire
